@@ sv/dcat_pkg.sv @@
// Shared widths, constants and stage record types for the dual-channel temperature alarm.
package dcat_pkg;

    // Averaging window and field widths.
    localparam int WINDOW   = 10;
    localparam int SAMPLE_W = 12;
    localparam int SUM_W    = 16;
    localparam int SLOT_W   = $clog2(WINDOW);
    localparam int TEMP_W   = 7;
    localparam int MEAN_W   = SAMPLE_W;

    // Alert threshold register.
    localparam logic [TEMP_W-1:0] THRESH_RESET = TEMP_W'(10);

    // Exact division of the running sum by WINDOW through a rounded-up reciprocal.
    localparam int              MEAN_SHIFT  = SUM_W + $clog2(WINDOW);
    localparam longint unsigned MEAN_MUL    =
        ((64'd1 << MEAN_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam int              MEAN_MUL_W  = SUM_W + 1;
    localparam int              MEAN_PROD_W = SUM_W + MEAN_MUL_W;

    // Scaling to degrees: floor(mean * SCALE_NUM / SCALE_DEN), folded into one product.
    localparam longint unsigned SCALE_NUM    = 64'd100;
    localparam longint unsigned SCALE_DEN    = 64'd4095;
    localparam int              SCALED_W     =
        $clog2(((64'd1 << MEAN_W) - 64'd1) * SCALE_NUM + 64'd1);
    localparam int              TEMP_SHIFT   = SCALED_W + $clog2(SCALE_DEN);
    localparam longint unsigned SCALE_RECIP  =
        ((64'd1 << TEMP_SHIFT) + SCALE_DEN - 64'd1) / SCALE_DEN;
    localparam longint unsigned TEMP_MUL     = SCALE_NUM * SCALE_RECIP;
    localparam int              TEMP_MUL_W   = $clog2(TEMP_MUL + 64'd1);
    localparam int              TEMP_PROD_W  = MEAN_W + TEMP_MUL_W;

    // Post-update running sums of both channels for one item.
    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] sum_first;
        logic [SUM_W-1:0] sum_second;
    } dcat_sums_t;

    // Scaled temperatures of both channels for one item.
    typedef struct packed {
        logic              valid;
        logic [TEMP_W-1:0] temp_first;
        logic [TEMP_W-1:0] temp_second;
    } dcat_temps_t;

endpackage

@@ sv/dcat_ring.sv @@
// Sample rings, write slots and running sums of both channels, with the update stage register.
module dcat_ring (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          channel,
    input  logic [dcat_pkg::SAMPLE_W-1:0] sample,
    output logic                          in_ready,
    output dcat_pkg::dcat_sums_t          sums,
    input  logic                          out_ready
);
    import dcat_pkg::*;

    logic [SAMPLE_W-1:0] ring_first_reg  [WINDOW];
    logic [SAMPLE_W-1:0] ring_second_reg [WINDOW];
    logic [SLOT_W-1:0]   slot_first_reg;
    logic [SLOT_W-1:0]   slot_second_reg;
    logic [SUM_W-1:0]    sum_first_reg;
    logic [SUM_W-1:0]    sum_second_reg;
    dcat_sums_t          sums_reg;

    logic [SLOT_W-1:0]   slot_sel;
    logic [SLOT_W-1:0]   slot_next;
    logic [SAMPLE_W-1:0] oldest;
    logic [SUM_W-1:0]    sum_sel;
    logic [SUM_W-1:0]    sum_next;
    logic                advance;

    assign in_ready = !sums_reg.valid || out_ready;
    assign advance  = in_valid && in_ready;
    assign sums     = sums_reg;

    always_comb
    begin
        slot_sel  = channel ? slot_second_reg : slot_first_reg;
        sum_sel   = channel ? sum_second_reg : sum_first_reg;
        oldest    = channel ? ring_second_reg[slot_sel] : ring_first_reg[slot_sel];
        sum_next  = sum_sel - SUM_W'(oldest) + SUM_W'(sample);
        slot_next = (slot_sel == SLOT_W'(WINDOW - 1)) ? '0 : slot_sel + SLOT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                ring_first_reg[i]  <= '0;
                ring_second_reg[i] <= '0;
            end
            slot_first_reg  <= '0;
            slot_second_reg <= '0;
            sum_first_reg   <= '0;
            sum_second_reg  <= '0;
            sums_reg        <= '0;
        end
        else
        begin
            if (advance)
            begin
                if (channel)
                begin
                    ring_second_reg[slot_sel] <= sample;
                    slot_second_reg           <= slot_next;
                    sum_second_reg            <= sum_next;
                    sums_reg.sum_first        <= sum_first_reg;
                    sums_reg.sum_second       <= sum_next;
                end
                else
                begin
                    ring_first_reg[slot_sel]  <= sample;
                    slot_first_reg            <= slot_next;
                    sum_first_reg             <= sum_next;
                    sums_reg.sum_first        <= sum_next;
                    sums_reg.sum_second       <= sum_second_reg;
                end
            end
            if (in_ready)
            begin
                sums_reg.valid <= in_valid;
            end
        end
    end

endmodule

@@ sv/dcat_scale.sv @@
// Mean and temperature stages: running sums to truncated means, then to degrees.
module dcat_scale (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dcat_pkg::dcat_sums_t  sums,
    output logic                  in_ready,
    output dcat_pkg::dcat_temps_t temps,
    input  logic                  out_ready
);
    import dcat_pkg::*;

    logic                   mean_valid_reg;
    logic [MEAN_W-1:0]      mean_first_reg;
    logic [MEAN_W-1:0]      mean_second_reg;
    dcat_temps_t            temps_reg;

    logic                   mean_ready;
    logic                   temp_ready;
    logic [MEAN_PROD_W-1:0] mean_prod_first;
    logic [MEAN_PROD_W-1:0] mean_prod_second;
    logic [TEMP_PROD_W-1:0] temp_prod_first;
    logic [TEMP_PROD_W-1:0] temp_prod_second;

    assign temp_ready = !temps_reg.valid || out_ready;
    assign mean_ready = !mean_valid_reg || temp_ready;
    assign in_ready   = mean_ready;
    assign temps      = temps_reg;

    // Division by the window size as a reciprocal multiply; exact over the sum range.
    assign mean_prod_first  = MEAN_PROD_W'(sums.sum_first)  * MEAN_PROD_W'(MEAN_MUL);
    assign mean_prod_second = MEAN_PROD_W'(sums.sum_second) * MEAN_PROD_W'(MEAN_MUL);

    // Scaling and division by full scale folded into one constant product.
    assign temp_prod_first  = TEMP_PROD_W'(mean_first_reg)  * TEMP_PROD_W'(TEMP_MUL);
    assign temp_prod_second = TEMP_PROD_W'(mean_second_reg) * TEMP_PROD_W'(TEMP_MUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_valid_reg <= 1'b0;
            temps_reg      <= '0;
        end
        else
        begin
            if (mean_ready)
            begin
                mean_valid_reg <= sums.valid;
            end
            if (temp_ready)
            begin
                temps_reg.valid <= mean_valid_reg;
            end
            if (temp_ready && mean_valid_reg)
            begin
                temps_reg.temp_first  <= temp_prod_first[TEMP_SHIFT +: TEMP_W];
                temps_reg.temp_second <= temp_prod_second[TEMP_SHIFT +: TEMP_W];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mean_ready && sums.valid)
        begin
            mean_first_reg  <= mean_prod_first[MEAN_SHIFT +: MEAN_W];
            mean_second_reg <= mean_prod_second[MEAN_SHIFT +: MEAN_W];
        end
    end

endmodule

@@ sv/dual_channel_average_temp_alarm_core.sv @@
// Top level of the dual-channel averaged temperature alarm.
//
// Each input item carries one 12-bit converter sample and the sensor channel it belongs to.
// The sample replaces the oldest entry in that channel's ring of the last WINDOW samples
// (ten in this build), and the channel's running sum is adjusted by the difference. Slots not
// yet written since reset count as zero, so a channel's average ramps up over its first
// WINDOW samples. Every item then produces one result item holding both channels' averaged
// temperatures in degrees (truncated mean scaled as 100 * mean / 4095), their absolute
// difference and an alert flag that is set when the difference strictly exceeds the alert
// threshold register (reset value 10; values above 100 simply keep the alert clear).
// The block accepts one item per clock cycle while the output side is not stalled; an item
// passes the input, ring update, mean, temperature and result registers in turn. The rate
// rests on the ring update stage, which reads the oldest sample and rewrites the running sum
// of a channel in the same cycle, so same-channel items follow without a gap. Both
// channels' sums are captured with each item, so a stall on the result side holds items in
// the pipeline without disturbing the results of earlier ones; the input side sees the stall
// only once every stage is full. The threshold register should be written only while no
// item is in flight.
module dual_channel_average_temp_alarm_core (
    input  logic                          clk,
    input  logic                          rst_n,
    // Sample channel.
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic                          channel,
    input  logic [dcat_pkg::SAMPLE_W-1:0] sample,
    // Result channel.
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [dcat_pkg::TEMP_W-1:0]   temp_first,
    output logic [dcat_pkg::TEMP_W-1:0]   temp_second,
    output logic [dcat_pkg::TEMP_W-1:0]   temp_gap,
    output logic                          alert,
    // Alert threshold register.
    input  logic                          cfg_write_enable,
    input  logic [dcat_pkg::TEMP_W-1:0]   cfg_write_data
);
    import dcat_pkg::*;

    // Input register.
    logic                in_valid_reg;
    logic                channel_reg;
    logic [SAMPLE_W-1:0] sample_reg;

    // Threshold and result registers.
    logic [TEMP_W-1:0]   threshold_reg;
    logic                result_valid_reg;
    logic [TEMP_W-1:0]   temp_first_reg;
    logic [TEMP_W-1:0]   temp_second_reg;
    logic [TEMP_W-1:0]   temp_gap_reg;
    logic                alert_reg;

    logic                accept;
    logic                ring_ready;
    logic                scale_ready;
    logic                out_ready;
    dcat_sums_t          sums;
    dcat_temps_t         temps;
    logic [TEMP_W-1:0]   gap;

    // The input register empties whenever the ring stage can take its item.
    assign sample_stall = in_valid_reg && !ring_ready;
    assign accept       = sample_valid && !sample_stall;

    assign out_ready    = !result_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (ring_ready)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            channel_reg <= channel;
            sample_reg  <= sample;
        end
    end

    dcat_ring u_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .channel   (channel_reg),
        .sample    (sample_reg),
        .in_ready  (ring_ready),
        .sums      (sums),
        .out_ready (scale_ready)
    );

    dcat_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .sums      (sums),
        .in_ready  (scale_ready),
        .temps     (temps),
        .out_ready (out_ready)
    );

    // Absolute difference of the two temperatures, formed ahead of the result register.
    assign gap = (temps.temp_first >= temps.temp_second) ?
                 (temps.temp_first - temps.temp_second) :
                 (temps.temp_second - temps.temp_first);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= THRESH_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_enable)
            begin
                threshold_reg <= cfg_write_data;
            end
            if (out_ready)
            begin
                result_valid_reg <= temps.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && temps.valid)
        begin
            temp_first_reg  <= temps.temp_first;
            temp_second_reg <= temps.temp_second;
            temp_gap_reg    <= gap;
            alert_reg       <= (gap > threshold_reg);
        end
    end

    assign result_valid = result_valid_reg;
    assign temp_first   = temp_first_reg;
    assign temp_second  = temp_second_reg;
    assign temp_gap     = temp_gap_reg;
    assign alert        = alert_reg;

endmodule
